FILE: rtl/tfcc_pkg.sv
// Shared types and constants for the four-corner touch calibrator.
package tfcc_pkg;

    localparam int COORD_BITS = 12;
    localparam int PHASE_BITS = 3;
    localparam int NUM_CORNERS = 4;
    localparam int CORNER_IDX_BITS = $clog2(NUM_CORNERS);

    localparam logic [PHASE_BITS-1:0] PH_CLOSED = 3'd0;
    localparam logic [PHASE_BITS-1:0] PH_START  = 3'd1;
    localparam logic [PHASE_BITS-1:0] PH_P1     = 3'd2;
    localparam logic [PHASE_BITS-1:0] PH_P2     = 3'd3;
    localparam logic [PHASE_BITS-1:0] PH_P3     = 3'd4;
    localparam logic [PHASE_BITS-1:0] PH_P4     = 3'd5;

    localparam logic CMD_POLL  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic   command;
        logic   touched;
        coord_t touch_x;
        coord_t touch_y;
    } sample_t;

    typedef struct packed {
        logic                  report_pressed;
        coord_t                report_x;
        coord_t                report_y;
        logic [PHASE_BITS-1:0] phase;
        logic                  cal_done;
        coord_t                x_min;
        coord_t                x_max;
        coord_t                y_min;
        coord_t                y_max;
    } result_t;

    // Truncated mean of two coordinates, sum kept one bit wider.
    function automatic coord_t avg2(input coord_t a, input coord_t b);
        logic [COORD_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[COORD_BITS:1];
    endfunction

endpackage

FILE: rtl/tfcc_core.sv
// Calibration phase state, corner storage and per-sample result logic.
module tfcc_core
    import tfcc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  sample_t sample,
    output result_t result
);

    logic                  active_reg, active_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic                  was_pressed_reg, was_pressed_next;
    coord_t                corner_x_reg [NUM_CORNERS];
    coord_t                corner_y_reg [NUM_CORNERS];

    logic                       corner_we;
    logic [PHASE_BITS-1:0]      phase_off;
    logic [CORNER_IDX_BITS-1:0] corner_idx;

    assign phase_off  = phase_reg - PH_P1;
    assign corner_idx = phase_off[CORNER_IDX_BITS-1:0];

    always_comb
    begin
        active_next      = active_reg;
        phase_next       = phase_reg;
        was_pressed_next = was_pressed_reg;
        corner_we        = 1'b0;
        result           = '0;

        if (sample.command == CMD_START)
        begin
            phase_next       = PH_START;
            active_next      = 1'b1;
            was_pressed_next = 1'b0;
        end
        else if (!active_reg)
        begin
            result.report_pressed = sample.touched;
            result.report_x       = sample.touch_x;
            result.report_y       = sample.touch_y;
        end
        else
        begin
            unique case (phase_reg) inside
                PH_CLOSED: phase_next = PH_START;
                PH_START:  phase_next = PH_P1;
                PH_P1, PH_P2, PH_P3, PH_P4:
                begin
                    if (sample.touched)
                    begin
                        was_pressed_next = 1'b1;
                        corner_we        = 1'b1;
                    end
                    else if (was_pressed_reg)
                    begin
                        was_pressed_next = 1'b0;
                        if (phase_reg == PH_P4)
                        begin
                            // The last corner was stored on an earlier pressed sample.
                            result.x_min    = avg2(corner_x_reg[0], corner_x_reg[1]);
                            result.x_max    = avg2(corner_x_reg[2], corner_x_reg[3]);
                            result.y_min    = avg2(corner_y_reg[1], corner_y_reg[3]);
                            result.y_max    = avg2(corner_y_reg[0], corner_y_reg[2]);
                            result.cal_done = 1'b1;
                            phase_next      = PH_CLOSED;
                            active_next     = 1'b0;
                        end
                        else
                        begin
                            phase_next = phase_reg + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        result.phase = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            phase_reg       <= PH_CLOSED;
            was_pressed_reg <= 1'b0;
        end
        else if (fire)
        begin
            active_reg      <= active_next;
            phase_reg       <= phase_next;
            was_pressed_reg <= was_pressed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && corner_we)
        begin
            corner_x_reg[corner_idx] <= sample.touch_x;
            corner_y_reg[corner_idx] <= sample.touch_y;
        end
    end

endmodule

FILE: rtl/touch_four_corner_calibrator_unit.sv
// Top level of the four-corner touch calibrator with its output register.
//
//  channel   direction  handshake                      payload
//  sample    in         sample_valid / sample_ready    sample_t
//  result    out        result_valid / result_ready    result_t
//
// Each accepted sample yields exactly one result, registered and shown in the cycle after it is accepted.
// The single output register sustains one sample per cycle while results are taken; a new sample
// is taken whenever the register is empty or its result is taken that cycle.
// A stalled result holds sample_ready low until it is taken.
// Reset clears the phase to closed and drops any pending result.
module touch_four_corner_calibrator_unit
    import tfcc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    output logic    sample_ready,
    input  sample_t sample,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic    fire;
    result_t core_result;
    logic    result_valid_reg;
    result_t result_reg;

    assign sample_ready = !result_valid_reg || result_ready;
    assign fire         = sample_valid && sample_ready;

    tfcc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .sample (sample),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (sample_ready)
        begin
            result_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= core_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: rtl/tfcc_checker.sv
// Port-level checks for the calibrator top level, bound to every instance.
module tfcc_checker
    import tfcc_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    sample_valid,
    input logic    sample_ready,
    input sample_t sample,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    // A pending result that is not taken must block new samples.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !sample_ready)
    else $error("sample accepted while result stalled");

    // Every accepted sample shows a result on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> result_valid)
    else $error("accepted sample produced no result");

    // Completion always returns the phase to closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.cal_done |-> result.phase == PH_CLOSED)
    else $error("cal_done without closed phase");

    // While calibration runs the report is released at the origin.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.phase != PH_CLOSED |->
            !result.report_pressed && result.report_x == '0 && result.report_y == '0)
    else $error("report not cleared during calibration");

    // A stalled result stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

endmodule

bind touch_four_corner_calibrator_unit tfcc_checker u_tfcc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
